### rtl/linked_list_reorder_engine_assert.svh
// Assertion macros for the linked list reorder engine checker.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef LINKED_LIST_REORDER_ENGINE_ASSERT_SVH
`define LINKED_LIST_REORDER_ENGINE_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define LLRE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next one
`define LLRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/llre_pkg.sv
// ----------------------------------------------------------------------------
// llre_pkg
// Shared widths, command codes and control types of the linked list
// reorder engine.
// ----------------------------------------------------------------------------
package llre_pkg;

    // Fixed field widths
    localparam int BOX_W  = 11;
    localparam int MODE_W = 3;
    localparam int SUM_W  = 20;

    // box_count after reset
    localparam logic [BOX_W-1:0] BOX_COUNT_RST = 11'd1;

    // Command codes
    typedef enum logic [MODE_W-1:0] {
        CMD_INIT   = 3'd0,
        CMD_LEFT   = 3'd1,
        CMD_RIGHT  = 3'd2,
        CMD_SWAP   = 3'd3,
        CMD_REV    = 3'd4,
        CMD_REPORT = 3'd5
    } t_mode;

    // Field write enables of the node memory
    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic label_we;
    } t_node_we;

endpackage

### rtl/llre_if.sv
// ----------------------------------------------------------------------------
// llre_if
// Valid/ready channels of the reorder engine: command requests in,
// report results out.
// ----------------------------------------------------------------------------

// Command channel
interface llre_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [llre_pkg::MODE_W-1:0]   mode;
    logic [llre_pkg::BOX_W-1:0]    first_box;
    logic [llre_pkg::BOX_W-1:0]    second_box;

    modport source (output valid, output mode, output first_box, output second_box,
                    input ready);
    modport sink   (input valid, input mode, input first_box, input second_box,
                    output ready);
endinterface

// Result channel
interface llre_res_if;
    logic                          valid;
    logic                          ready;
    logic [llre_pkg::SUM_W-1:0]    odd_position_sum;

    modport source (output valid, output odd_position_sum, input ready);
    modport sink   (input valid, input odd_position_sum, output ready);
endinterface

### rtl/llre_node_mem.sv
// ----------------------------------------------------------------------------
// llre_node_mem
// Node store: next link, previous link and label of every list node.
// One write port with per-field enables, two registered read ports.
// ----------------------------------------------------------------------------
module llre_node_mem #(
    parameter int DEPTH = 1025,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic [AW-1:0]                i_rd_addr_a,
    input  logic [AW-1:0]                i_rd_addr_b,
    input  logic [AW-1:0]                i_wr_addr,
    input  llre_pkg::t_node_we           i_we,
    input  logic [AW-1:0]                i_wr_next,
    input  logic [AW-1:0]                i_wr_prev,
    input  logic [llre_pkg::BOX_W-1:0]   i_wr_label,
    output logic [AW-1:0]                o_a_next,
    output logic [AW-1:0]                o_a_prev,
    output logic [llre_pkg::BOX_W-1:0]   o_a_label,
    output logic [AW-1:0]                o_b_next,
    output logic [AW-1:0]                o_b_prev
);

    logic [AW-1:0]              r_next  [DEPTH];
    logic [AW-1:0]              r_prev  [DEPTH];
    logic [llre_pkg::BOX_W-1:0] r_label [DEPTH];

    // Field-masked write, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we.next_we) begin
            r_next[i_wr_addr] <= i_wr_next;
        end
        if (i_we.prev_we) begin
            r_prev[i_wr_addr] <= i_wr_prev;
        end
        if (i_we.label_we) begin
            r_label[i_wr_addr] <= i_wr_label;
        end
        o_a_next  <= r_next[i_rd_addr_a];
        o_a_prev  <= r_prev[i_rd_addr_a];
        o_a_label <= r_label[i_rd_addr_a];
        o_b_next  <= r_next[i_rd_addr_b];
        o_b_prev  <= r_prev[i_rd_addr_b];
    end

endmodule

### rtl/llre_map_mem.sv
// ----------------------------------------------------------------------------
// llre_map_mem
// Label to node map. One write port, two registered read ports.
// ----------------------------------------------------------------------------
module llre_map_mem #(
    parameter int DEPTH = 1025,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic [AW-1:0]   i_rd_addr_a,
    input  logic [AW-1:0]   i_rd_addr_b,
    input  logic            i_we,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [AW-1:0]   i_wr_data,
    output logic [AW-1:0]   o_a_data,
    output logic [AW-1:0]   o_b_data
);

    logic [AW-1:0] r_map [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_map[i_wr_addr] <= i_wr_data;
        end
        o_a_data <= r_map[i_rd_addr_a];
        o_b_data <= r_map[i_rd_addr_b];
    end

endmodule

### rtl/linked_list_reorder_engine.sv
// ----------------------------------------------------------------------------
// linked_list_reorder_engine
// Doubly linked list of labeled boxes with a reverse flag, kept in a node
// memory and a label map, driven by a command sequencer.
// ----------------------------------------------------------------------------
// One command request is taken at a time; ready is high only while the
// sequencer is idle. Its steps are set by the single write port of the node
// memory and its registered reads: reverse, unused modes and ignored
// moves/swaps finish in the idle state; a swap writes label and map of each
// box; a move reads the map, then both nodes, stops if already in place,
// else writes next[p], prev[q], next[a], both links of x, prev[b];
// initialise writes nodes 0..n, n = min(box_count, MAX_BOXES), one node per
// cycle; report follows one link per cycle, plus any wait for the result
// register to be emptied; it lets a new request in while a result waits.
module linked_list_reorder_engine #(
    parameter int MAX_BOXES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [llre_pkg::BOX_W-1:0]   i_cfg_wdata,
    llre_cmd_if.sink                     i_cmd,
    llre_res_if.source                   o_res
);

    localparam int DEPTH = MAX_BOXES + 1;
    localparam int NW    = $clog2(DEPTH);
    localparam int BW    = llre_pkg::BOX_W;
    localparam int SW    = llre_pkg::SUM_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_INIT = 12'b0000_0000_0010,
        S_MAP  = 12'b0000_0000_0100,
        S_SWAP = 12'b0000_0000_1000,
        S_NODE = 12'b0000_0001_0000,
        S_W_P  = 12'b0000_0010_0000,
        S_W_Q  = 12'b0000_0100_0000,
        S_W_A  = 12'b0000_1000_0000,
        S_W_X  = 12'b0001_0000_0000,
        S_W_B  = 12'b0010_0000_0000,
        S_RPT  = 12'b0100_0000_0000,
        S_POST = 12'b1000_0000_0000
    } t_state;

    // Control state
    t_state           r_state, n_state;
    logic [BW-1:0]    r_box_count;
    logic [BW-1:0]    r_live, n_live;
    logic             r_rev, n_rev;
    logic             r_out_valid, n_out_valid;

    // Working payload
    logic [BW-1:0]    r_idx, n_idx;
    logic [BW-1:0]    r_pos, n_pos;
    logic [BW-1:0]    r_x, n_x, r_y, n_y;
    logic             r_left, n_left, r_swap, n_swap;
    logic [NW-1:0]    r_nx, n_nx, r_ny, n_ny;
    logic [NW-1:0]    r_p, n_p, r_q, n_q, r_a, n_a, r_b, n_b;
    logic [SW-1:0]    r_sum, n_sum, r_out_sum, n_out_sum;

    // Memory ports
    logic [NW-1:0]        nm_rd_a, nm_rd_b, nm_wr_addr, nm_wr_next, nm_wr_prev;
    llre_pkg::t_node_we   nm_we;
    logic [BW-1:0]        nm_wr_label, nm_a_label;
    logic [NW-1:0]        nm_a_next, nm_a_prev, nm_b_next, nm_b_prev;
    logic [NW-1:0]        mm_rd_a, mm_rd_b, mm_wr_addr, mm_wr_data, mm_a_data, mm_b_data;
    logic                 mm_we;

    // Decode helpers
    logic             cmd_acc;
    logic             args_ok;
    logic [BW-1:0]    live_init;
    logic [NW-1:0]    link;
    logic [NW-1:0]    ins_a, ins_b;

    llre_node_mem #(.DEPTH(DEPTH)) u_node_mem (
        .i_clk       (i_clk),
        .i_rd_addr_a (nm_rd_a),
        .i_rd_addr_b (nm_rd_b),
        .i_wr_addr   (nm_wr_addr),
        .i_we        (nm_we),
        .i_wr_next   (nm_wr_next),
        .i_wr_prev   (nm_wr_prev),
        .i_wr_label  (nm_wr_label),
        .o_a_next    (nm_a_next),
        .o_a_prev    (nm_a_prev),
        .o_a_label   (nm_a_label),
        .o_b_next    (nm_b_next),
        .o_b_prev    (nm_b_prev)
    );

    llre_map_mem #(.DEPTH(DEPTH)) u_map_mem (
        .i_clk       (i_clk),
        .i_rd_addr_a (mm_rd_a),
        .i_rd_addr_b (mm_rd_b),
        .i_we        (mm_we),
        .i_wr_addr   (mm_wr_addr),
        .i_wr_data   (mm_wr_data),
        .o_a_data    (mm_a_data),
        .o_b_data    (mm_b_data)
    );

    // Handshakes
    assign i_cmd.ready            = (r_state == S_IDLE);
    assign cmd_acc                = i_cmd.valid & i_cmd.ready;
    assign o_res.valid            = r_out_valid;
    assign o_res.odd_position_sum = r_out_sum;

    // Box labels must lie in 1..live_count and differ
    assign args_ok = (i_cmd.first_box != '0) && (i_cmd.second_box != '0)
                  && (i_cmd.first_box <= r_live) && (i_cmd.second_box <= r_live)
                  && (i_cmd.first_box != i_cmd.second_box);

    // List length saturates at MAX_BOXES
    assign live_init = (32'(r_box_count) > MAX_BOXES) ? BW'(MAX_BOXES) : r_box_count;

    // Report walk direction
    assign link = r_rev ? nm_a_prev : nm_a_next;

    // Insertion point: between ins_a and ins_b
    assign ins_a = r_left ? nm_b_prev : r_ny;
    assign ins_b = r_left ? r_ny : nm_b_next;

    // Label map reads come straight from the request
    assign mm_rd_a = NW'(i_cmd.first_box);
    assign mm_rd_b = NW'(i_cmd.second_box);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_rev       = r_rev;
        n_out_valid = r_out_valid & ~o_res.ready;
        n_out_sum   = r_out_sum;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_x         = r_x;
        n_y         = r_y;
        n_left      = r_left;
        n_swap      = r_swap;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_p         = r_p;
        n_q         = r_q;
        n_a         = r_a;
        n_b         = r_b;
        n_sum       = r_sum;

        nm_rd_a     = '0;
        nm_rd_b     = '0;
        nm_wr_addr  = '0;
        nm_we       = '0;
        nm_wr_next  = '0;
        nm_wr_prev  = '0;
        nm_wr_label = '0;
        mm_we       = 1'b0;
        mm_wr_addr  = '0;
        mm_wr_data  = '0;

        unique case (r_state)
            S_IDLE: begin
                // Node 0 is read ahead for a report
                nm_rd_a = '0;
                if (cmd_acc) begin
                    unique case (i_cmd.mode)
                        llre_pkg::CMD_INIT: begin
                            n_live  = live_init;
                            n_rev   = 1'b0;
                            n_idx   = '0;
                            n_state = S_INIT;
                        end
                        llre_pkg::CMD_LEFT, llre_pkg::CMD_RIGHT, llre_pkg::CMD_SWAP: begin
                            n_x    = i_cmd.first_box;
                            n_y    = i_cmd.second_box;
                            n_swap = (i_cmd.mode == llre_pkg::CMD_SWAP);
                            n_left = (i_cmd.mode == llre_pkg::CMD_LEFT) ^ r_rev;
                            if (args_ok) begin
                                n_state = S_MAP;
                            end
                        end
                        llre_pkg::CMD_REV: begin
                            n_rev = ~r_rev;
                        end
                        llre_pkg::CMD_REPORT: begin
                            n_pos   = '0;
                            n_sum   = '0;
                            n_state = S_RPT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Build ring 0..n, one node per cycle
            S_INIT: begin
                nm_wr_addr  = NW'(r_idx);
                nm_we       = '{next_we: 1'b1, prev_we: 1'b1, label_we: 1'b1};
                nm_wr_next  = (r_idx == r_live) ? '0 : NW'(r_idx + BW'(1));
                nm_wr_prev  = (r_idx == '0) ? NW'(r_live) : NW'(r_idx - BW'(1));
                nm_wr_label = r_idx;
                mm_we       = 1'b1;
                mm_wr_addr  = NW'(r_idx);
                mm_wr_data  = NW'(r_idx);
                n_idx       = r_idx + BW'(1);
                if (r_idx == r_live) begin
                    n_state = S_IDLE;
                end
            end

            // Node numbers of both boxes are here
            S_MAP: begin
                n_nx = mm_a_data;
                n_ny = mm_b_data;
                if (r_swap) begin
                    // Node and label maps stay inverse, so no label read
                    nm_wr_addr  = mm_a_data;
                    nm_we       = '{next_we: 1'b0, prev_we: 1'b0, label_we: 1'b1};
                    nm_wr_label = r_y;
                    mm_we       = 1'b1;
                    mm_wr_addr  = NW'(r_x);
                    mm_wr_data  = mm_b_data;
                    n_state     = S_SWAP;
                end else begin
                    nm_rd_a = mm_a_data;
                    nm_rd_b = mm_b_data;
                    n_state = S_NODE;
                end
            end

            S_SWAP: begin
                nm_wr_addr  = r_ny;
                nm_we       = '{next_we: 1'b0, prev_we: 1'b0, label_we: 1'b1};
                nm_wr_label = r_x;
                mm_we       = 1'b1;
                mm_wr_addr  = NW'(r_y);
                mm_wr_data  = r_nx;
                n_state     = S_IDLE;
            end

            // Links of both nodes are here; skip if already in place
            S_NODE: begin
                n_p = nm_a_prev;
                n_q = nm_a_next;
                n_a = ins_a;
                n_b = ins_b;
                if ((ins_a == r_nx) || (ins_b == r_nx)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_W_P;
                end
            end

            // Unlink: next[p] = q
            S_W_P: begin
                nm_wr_addr = r_p;
                nm_we      = '{next_we: 1'b1, prev_we: 1'b0, label_we: 1'b0};
                nm_wr_next = r_q;
                n_state    = S_W_Q;
            end

            // Unlink: prev[q] = p
            S_W_Q: begin
                nm_wr_addr = r_q;
                nm_we      = '{next_we: 1'b0, prev_we: 1'b1, label_we: 1'b0};
                nm_wr_prev = r_p;
                n_state    = S_W_A;
            end

            // Link: next[a] = x
            S_W_A: begin
                nm_wr_addr = r_a;
                nm_we      = '{next_we: 1'b1, prev_we: 1'b0, label_we: 1'b0};
                nm_wr_next = r_nx;
                n_state    = S_W_X;
            end

            // Link: x between a and b
            S_W_X: begin
                nm_wr_addr = r_nx;
                nm_we      = '{next_we: 1'b1, prev_we: 1'b1, label_we: 1'b0};
                nm_wr_next = r_b;
                nm_wr_prev = r_a;
                n_state    = S_W_B;
            end

            // Link: prev[b] = x
            S_W_B: begin
                nm_wr_addr = r_b;
                nm_we      = '{next_we: 1'b0, prev_we: 1'b1, label_we: 1'b0};
                nm_wr_prev = r_nx;
                n_state    = S_IDLE;
            end

            // Word of the node at r_pos is here
            S_RPT: begin
                n_sum = r_pos[0] ? (r_sum + SW'(nm_a_label)) : r_sum;
                if (r_pos == r_live) begin
                    n_state = S_POST;
                end else begin
                    nm_rd_a = link;
                    n_pos   = r_pos + BW'(1);
                end
            end

            // Hand the sum to the result register once it is free
            S_POST: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_sum;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
            r_box_count <= llre_pkg::BOX_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_box_count <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_x       <= n_x;
        r_y       <= n_y;
        r_left    <= n_left;
        r_swap    <= n_swap;
        r_nx      <= n_nx;
        r_ny      <= n_ny;
        r_p       <= n_p;
        r_q       <= n_q;
        r_a       <= n_a;
        r_b       <= n_b;
        r_sum     <= n_sum;
        r_out_sum <= n_out_sum;
    end

endmodule

### rtl/llre_checker.sv
// ----------------------------------------------------------------------------
// llre_checker
// Port-level checks of the reorder engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "linked_list_reorder_engine_assert.svh"

module llre_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  logic [llre_pkg::MODE_W-1:0]   i_cmd_mode,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [llre_pkg::SUM_W-1:0]    i_out_sum
);

    // Result handshake
    `LLRE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `LLRE_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_sum), "result changed while stalled")

    // A result is loaded only by the busy sequencer
    `LLRE_ASSERT_ALWAYS(a_out_busy, $rose(i_out_valid) |-> !$past(i_cmd_ready), "result appeared while idle")

    // Only a report request yields a result
    `LLRE_ASSERT_NEXT(a_no_spurious, i_cmd_valid && i_cmd_ready && (i_cmd_mode != llre_pkg::CMD_REPORT), !$rose(i_out_valid), "result without a report")

    // Initialise and report keep the engine busy
    `LLRE_ASSERT_NEXT(a_walk_busy, i_cmd_valid && i_cmd_ready && ((i_cmd_mode == llre_pkg::CMD_REPORT) || (i_cmd_mode == llre_pkg::CMD_INIT)), !i_cmd_ready, "ready during list walk")

endmodule

bind linked_list_reorder_engine llre_checker u_llre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_cmd_mode  (i_cmd.mode),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_sum   (o_res.odd_position_sum)
);

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linked list reorder engine: a directed table of
// command requests, then phases of random requests at varied box counts, all
// scored against an in-bench model of the box list and its reverse flag.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_BOXES    = 1024;
    // Longest request is an initialise or report over all boxes
    localparam int SETTLE_CYC   = MAX_BOXES + 16;
    // Slowest request plus worst gap and stall, taken many times over
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 1820;
    localparam int N_DIRECTED   = 28;

    // Mode codes the block leaves unused
    localparam logic [llre_pkg::MODE_W-1:0] MODE_UNUSED_A = 3'd6;
    localparam logic [llre_pkg::MODE_W-1:0] MODE_UNUSED_B = 3'd7;

    // One row of the directed table: a request or a box_count write
    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;
    typedef struct packed {
        t_row_kind                       kind;
        logic [llre_pkg::MODE_W-1:0]     mode;
        logic [llre_pkg::BOX_W-1:0]      fbox;
        logic [llre_pkg::BOX_W-1:0]      sbox;
        logic                            typed;
        logic [llre_pkg::SUM_W-1:0]      sum;
    } t_row;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        // empty list before any initialise
        '{ROW_REQ, llre_pkg::CMD_REPORT, 11'd0,    11'd0,    1'b1, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_LEFT,   11'd1,    11'd2,    1'b0, 20'd0},
        '{ROW_REQ, MODE_UNUSED_A,        11'd5,    11'd5,    1'b0, 20'd0},
        '{ROW_REQ, MODE_UNUSED_B,        11'd2047, 11'd2047, 1'b0, 20'd0},
        // box_count after reset is one
        '{ROW_REQ, llre_pkg::CMD_INIT,   11'd0,    11'd0,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_REPORT, 11'd0,    11'd0,    1'b1, 20'd1},
        // five boxes: moves, in-place moves, swap, reverse
        '{ROW_CFG, llre_pkg::CMD_INIT,   11'd5,    11'd0,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_INIT,   11'd0,    11'd0,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_REPORT, 11'd0,    11'd0,    1'b1, 20'd9},
        '{ROW_REQ, llre_pkg::CMD_LEFT,   11'd1,    11'd3,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_LEFT,   11'd1,    11'd3,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_RIGHT,  11'd5,    11'd2,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_RIGHT,  11'd5,    11'd2,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_SWAP,   11'd2,    11'd4,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_REV,    11'd0,    11'd0,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_LEFT,   11'd3,    11'd4,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_RIGHT,  11'd1,    11'd5,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_REPORT, 11'd0,    11'd0,    1'b0, 20'd0},
        // ignored: same box, label zero, label past the list end
        '{ROW_REQ, llre_pkg::CMD_LEFT,   11'd3,    11'd3,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_SWAP,   11'd0,    11'd2,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_RIGHT,  11'd6,    11'd1,    1'b0, 20'd0},
        // zero boxes gives an empty list
        '{ROW_CFG, llre_pkg::CMD_INIT,   11'd0,    11'd0,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_INIT,   11'd0,    11'd0,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_REPORT, 11'd0,    11'd0,    1'b1, 20'd0},
        // full field saturates to the largest list, then reverse
        '{ROW_CFG, llre_pkg::CMD_INIT,   11'd2047, 11'd0,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_INIT,   11'd0,    11'd0,    1'b0, 20'd0},
        '{ROW_REQ, llre_pkg::CMD_REPORT, 11'd0,    11'd0,    1'b1, 20'd262144},
        '{ROW_REQ, llre_pkg::CMD_REV,    11'd0,    11'd0,    1'b0, 20'd0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [llre_pkg::BOX_W-1:0]    i_cfg_wdata = '0;

    llre_cmd_if cmd_if ();
    llre_res_if res_if ();

    linked_list_reorder_engine #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Box list model: sentinel node 0 closes the ring
    logic [llre_pkg::BOX_W-1:0]   nxt_node [0:MAX_BOXES];
    logic [llre_pkg::BOX_W-1:0]   prv_node [0:MAX_BOXES];
    logic [llre_pkg::BOX_W-1:0]   node_lbl [0:MAX_BOXES];
    logic [llre_pkg::BOX_W-1:0]   lbl_node [0:MAX_BOXES];
    logic                         flipped = 1'b0;
    int                           list_len = 0;
    logic [llre_pkg::BOX_W-1:0]   box_count_q = llre_pkg::BOX_COUNT_RST;

    logic [llre_pkg::SUM_W-1:0]   pending_sums [$];
    int                           mismatches = 0;
    int                           quiet_cycles = 0;
    int                           res_hold = 0;
    bit                           no_idle = 1'b0;

    task automatic unlink_box(input logic [llre_pkg::BOX_W-1:0] nd);
        logic [llre_pkg::BOX_W-1:0] p, q;
        p = prv_node[nd];
        q = nxt_node[nd];
        nxt_node[p] = q;
        prv_node[q] = p;
    endtask

    task automatic place_before(input logic [llre_pkg::BOX_W-1:0] nd,
                                input logic [llre_pkg::BOX_W-1:0] at);
        logic [llre_pkg::BOX_W-1:0] p;
        p = prv_node[at];
        nxt_node[p] = nd;
        prv_node[nd] = p;
        nxt_node[nd] = at;
        prv_node[at] = nd;
    endtask

    // Advance the model by one request; flags whether it yields a report sum
    task automatic apply_request(input logic [llre_pkg::MODE_W-1:0] md,
                                 input logic [llre_pkg::BOX_W-1:0] a,
                                 input logic [llre_pkg::BOX_W-1:0] b, output bit has_sum,
                                 output logic [llre_pkg::SUM_W-1:0] sum);
        logic [llre_pkg::BOX_W-1:0] na, nb, t, nd;
        int                         n, j, acc;
        bit                         go_left;
        has_sum = 1'b0;
        sum = '0;
        case (md)
            llre_pkg::CMD_INIT: begin
                n = (box_count_q > MAX_BOXES) ? MAX_BOXES : int'(box_count_q);
                list_len = n;
                flipped = 1'b0;
                nxt_node[0] = '0;
                prv_node[0] = '0;
                for (j = 1; j <= n; j++) begin
                    node_lbl[j] = llre_pkg::BOX_W'(j);
                    lbl_node[j] = llre_pkg::BOX_W'(j);
                    place_before(llre_pkg::BOX_W'(j), '0);
                end
            end
            llre_pkg::CMD_REV: begin
                flipped = ~flipped;
            end
            llre_pkg::CMD_REPORT: begin
                // walk in the current direction, summing odd positions
                nd = '0;
                acc = 0;
                for (j = 1; j <= list_len; j++) begin
                    nd = flipped ? prv_node[nd] : nxt_node[nd];
                    if (j % 2 == 1) acc += node_lbl[nd];
                end
                sum = acc[llre_pkg::SUM_W-1:0];
                has_sum = 1'b1;
            end
            llre_pkg::CMD_LEFT, llre_pkg::CMD_RIGHT, llre_pkg::CMD_SWAP: begin
                if (a != 0 && b != 0 && a <= list_len && b <= list_len && a != b) begin
                    na = lbl_node[a];
                    nb = lbl_node[b];
                    if (md == llre_pkg::CMD_SWAP) begin
                        t = node_lbl[na];
                        node_lbl[na] = node_lbl[nb];
                        node_lbl[nb] = t;
                        lbl_node[a] = nb;
                        lbl_node[b] = na;
                    end else begin
                        // reverse flag exchanges left and right
                        go_left = (md == llre_pkg::CMD_LEFT) ^ flipped;
                        if (go_left) begin
                            if (prv_node[nb] != na) begin
                                unlink_box(na);
                                place_before(na, nb);
                            end
                        end else if (nxt_node[nb] != na) begin
                            unlink_box(na);
                            place_before(na, nxt_node[nb]);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Present one request; called and returns at a falling edge
    task automatic send_request(input logic [llre_pkg::MODE_W-1:0] md,
                                input logic [llre_pkg::BOX_W-1:0] a,
                                input logic [llre_pkg::BOX_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            cmd_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.mode = md;
        cmd_if.first_box = a;
        cmd_if.second_box = b;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
    endtask

    // Predict, queue any expected sum, then drive the request
    task automatic issue(input logic [llre_pkg::MODE_W-1:0] md,
                         input logic [llre_pkg::BOX_W-1:0] a,
                         input logic [llre_pkg::BOX_W-1:0] b, input bit typed,
                         input logic [llre_pkg::SUM_W-1:0] typed_sum);
        bit                         has_sum;
        logic [llre_pkg::SUM_W-1:0] sum;
        apply_request(md, a, b, has_sum, sum);
        if (has_sum) pending_sums.push_back(typed ? typed_sum : sum);
        send_request(md, a, b);
    endtask

    // box_count write, only once the block has gone idle
    task automatic write_box_count(input logic [llre_pkg::BOX_W-1:0] v);
        cmd_if.valid = 1'b0;
        while (pending_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        box_count_q = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Random request: mostly valid moves and swaps on live labels, some
    // in-place moves, some broken labels and raw noise
    task automatic pick_request(output logic [llre_pkg::MODE_W-1:0] md,
                                output logic [llre_pkg::BOX_W-1:0] a,
                                output logic [llre_pkg::BOX_W-1:0] b);
        int                         r;
        logic [llre_pkg::BOX_W-1:0] nb;
        r = $urandom_range(0, 99);
        a = llre_pkg::BOX_W'($urandom_range(0, 2047));
        b = llre_pkg::BOX_W'($urandom_range(0, 2047));
        if (r < 3) begin
            md = llre_pkg::CMD_INIT;
        end else if (r < 9) begin
            md = llre_pkg::CMD_REV;
        end else if (r < 21) begin
            md = llre_pkg::CMD_REPORT;
        end else if (r < 25) begin
            md = llre_pkg::MODE_W'($urandom_range(llre_pkg::CMD_INIT, MODE_UNUSED_B));
        end else if (r < 30) begin
            md = llre_pkg::MODE_W'($urandom_range(llre_pkg::CMD_LEFT, llre_pkg::CMD_SWAP));
            case ($urandom_range(0, 2))
                0: begin
                    a = llre_pkg::BOX_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
                    b = a;
                end
                1: a = '0;
                default: a = llre_pkg::BOX_W'($urandom_range(list_len + 1, 2047));
            endcase
        end else begin
            md = llre_pkg::MODE_W'($urandom_range(llre_pkg::CMD_LEFT, llre_pkg::CMD_SWAP));
            if (list_len < 2) begin
                a = llre_pkg::BOX_W'($urandom_range(1, 3));
                b = llre_pkg::BOX_W'($urandom_range(1, 3));
            end else begin
                b = llre_pkg::BOX_W'($urandom_range(1, list_len));
                a = llre_pkg::BOX_W'($urandom_range(1, list_len));
                if ($urandom_range(0, 3) == 0) begin
                    // a neighbor of the reference box, often already in place
                    nb = $urandom_range(0, 1) ? nxt_node[lbl_node[b]] : prv_node[lbl_node[b]];
                    if (nb != 0) a = node_lbl[nb];
                end
                if (a == b) begin
                    a = (a == list_len) ? llre_pkg::BOX_W'(1) : a + llre_pkg::BOX_W'(1);
                end
            end
        end
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // Result sink: per-result stall drawn when the previous one is taken
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (res_hold > 0) begin
                res_if.ready = 1'b0;
                res_hold--;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // Result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (res_if.valid && res_if.ready) begin
                res_hold = no_idle ? 0 : $urandom_range(0, 4);
                if (pending_sums.size() == 0) begin
                    report_error($sformatf("report result %0d with no report pending",
                                           res_if.odd_position_sum));
                end else if (res_if.odd_position_sum !== pending_sums[0]) begin
                    report_error($sformatf("odd_position_sum: expected %0d, got %0d",
                                           pending_sums[0], res_if.odd_position_sum));
                    void'(pending_sums.pop_front());
                end else begin
                    void'(pending_sums.pop_front());
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("linked_list_reorder_engine test failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int                          i, done, left, phase;
        logic [llre_pkg::MODE_W-1:0] md;
        logic [llre_pkg::BOX_W-1:0]  a, b, cnt;
        logic [llre_pkg::BOX_W-1:0]  edge_counts [6];
        edge_counts = '{11'd1024, 11'd2047, 11'd0, 11'd2, 11'd1, 11'd1025};
        cmd_if.valid = 1'b0;
        cmd_if.mode = llre_pkg::CMD_INIT;
        cmd_if.first_box = '0;
        cmd_if.second_box = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_box_count(DIRECTED[i].fbox);
            end else begin
                issue(DIRECTED[i].mode, DIRECTED[i].fbox, DIRECTED[i].sbox,
                      DIRECTED[i].typed, DIRECTED[i].sum);
            end
        end

        // random phases, each at a new box_count
        done = 0;
        phase = 0;
        while (done < RANDOM_ITEMS) begin
            if (phase < 6) begin
                cnt = edge_counts[phase];
            end else begin
                case ($urandom_range(0, 9))
                    0:       cnt = llre_pkg::BOX_W'($urandom_range(0, 2047));
                    1, 2:    cnt = llre_pkg::BOX_W'($urandom_range(41, 300));
                    default: cnt = llre_pkg::BOX_W'($urandom_range(1, 40));
                endcase
            end
            write_box_count(cnt);
            issue(llre_pkg::CMD_INIT, llre_pkg::BOX_W'($urandom_range(0, 2047)),
                  llre_pkg::BOX_W'($urandom_range(0, 2047)), 1'b0, '0);
            left = $urandom_range(60, 140);
            while (left > 0 && done < RANDOM_ITEMS) begin
                if ($urandom_range(0, 39) == 0) no_idle = ($urandom_range(0, 3) == 0);
                pick_request(md, a, b);
                issue(md, a, b, 1'b0, '0);
                done++;
                left--;
            end
            phase++;
        end
        cmd_if.valid = 1'b0;

        // drain
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("linked_list_reorder_engine test passed");
        end else begin
            $display("linked_list_reorder_engine test failed");
        end
        $finish;
    end

endmodule
